// ===== src/esc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the mesh edge solidity checker.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned MaxEdgesDef   = 1024;
  localparam int unsigned VertexBitsDef = 16;
  localparam int unsigned LanesDef      = 4;
  localparam int unsigned VtxInW        = 16;

  // edge direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;  // min to max
  localparam logic [1:0] DIR_REV  = 2'd2;  // max to min
  localparam logic [1:0] DIR_FULL = 2'd3;

  localparam logic [1:0] CNT_MAX = 2'd3;

  // edges of a triangle, in processing order
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  // per-lane read result
  typedef struct packed {
    logic       hit;
    logic [1:0] cnt;
    logic [1:0] dir;
  } lane_rd_t;

endpackage

// ===== src/mesh_edge_solidity_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_edge_solidity_checker
// Streams triangles into a banked edge table and reports closed, orientable,
// manifold, solid and overflow flags after the last triangle of a mesh.
// ----------------------------------------------------------------------------
// Per edge: a key step, then, with entries in use, one registered read and one
//   lane compare per row of LANES entries until a hit or the end of the entries
//   in use, then an update. A triangle runs edges AB, BC and CA in turn; no new
//   triangle is taken until it is through. The last triangle of a mesh then loads
//   the result register, and waits there while an earlier flag item is still held.
// Reset: tables need no clearing (fill count); flags and counters clear at
//   once, require_fan resets to 1. The table empties at each mesh end.
module mesh_edge_solidity_checker import esc_pkg::*; #(
  parameter int unsigned MAX_EDGES   = MaxEdgesDef,
  parameter int unsigned VERTEX_BITS = VertexBitsDef,
  parameter int unsigned LANES       = LanesDef     // power of two, >= 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // triangle items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // vertex_a, vertex_b, vertex_c
  input  logic        s_axis_tlast,   // last_face
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // closed, orientable, manifold, solid,
                                      // overflow, 3 zero bits
  // require_fan register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_data_i
);

  localparam int unsigned KeyW     = 2 * VERTEX_BITS;
  localparam int unsigned LaneBits = $clog2(LANES);
  localparam int unsigned Rows     = (MAX_EDGES + LANES - 1) / LANES;
  localparam int unsigned RowBits  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned CntW     = $clog2(MAX_EDGES + 1);
  localparam int unsigned IdxW     = RowBits + LaneBits + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_KEY  = 6'b000010,
    S_READ = 6'b000100,
    S_CMP  = 6'b001000,
    S_UPD  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // latched triangle
  logic [VtxInW-1:0] va_q, vb_q, vc_q;
  logic              last_q;
  logic [1:0]        edge_q;

  // current edge
  logic [VERTEX_BITS-1:0] from_q, to_q;
  logic [KeyW-1:0]        key_q;
  logic [RowBits-1:0]     row_q;
  logic                   hit_q;
  logic [1:0]             old_cnt_q, old_dir_q;
  logic [LaneBits-1:0]    wr_lane_q;
  logic [RowBits-1:0]     wr_row_q;

  // mesh state
  logic [CntW-1:0] used_q, n1_q, n2_q;
  logic            orient_ok_q, manifold_ok_q, overflow_q, require_fan_q;

  logic            out_valid_q;
  logic [4:0]      out_flags_q;

  // lanes and merge
  lane_rd_t            lane_rd [LANES];
  lane_rd_t            mrg_rd;
  logic [LaneBits-1:0] mrg_lane;
  logic                lane_we;
  logic [1:0]          new_cnt, new_dir;
  logic                orient_fail;

  logic [VERTEX_BITS-1:0] v_from, v_to, v_lo, v_hi;
  logic [IdxW-1:0]        used_x, row_base;
  logic                   scan_end;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_flags_q};

  assign used_x   = IdxW'(used_q);
  assign row_base = IdxW'({row_q, {LaneBits{1'b0}}});
  assign scan_end = (row_base + IdxW'(LANES)) >= used_x;

  // edge end points from the latched triangle
  always_comb begin
    case (edge_q)
      EDGE_AB: begin
        v_from = VERTEX_BITS'(32'(va_q));
        v_to   = VERTEX_BITS'(32'(vb_q));
      end
      EDGE_BC: begin
        v_from = VERTEX_BITS'(32'(vb_q));
        v_to   = VERTEX_BITS'(32'(vc_q));
      end
      default: begin
        v_from = VERTEX_BITS'(32'(vc_q));
        v_to   = VERTEX_BITS'(32'(va_q));
      end
    endcase
    v_lo = (v_from < v_to) ? v_from : v_to;
    v_hi = (v_from < v_to) ? v_to : v_from;
  end

  // new count and direction of the edge being updated
  always_comb begin
    new_cnt     = (old_cnt_q < CNT_MAX) ? old_cnt_q + 2'd1 : CNT_MAX;
    orient_fail = 1'b0;
    case (old_dir_q)
      DIR_NONE: begin
        new_dir     = (from_q < to_q) ? DIR_FWD : DIR_REV;
        orient_fail = (from_q == to_q);
      end
      DIR_FWD: begin
        new_dir     = DIR_FULL;
        orient_fail = !(from_q > to_q);
      end
      DIR_REV: begin
        new_dir     = DIR_FULL;
        orient_fail = !(from_q < to_q);
      end
      default: begin
        new_dir     = DIR_FULL;
        orient_fail = 1'b1;
      end
    endcase
  end

  // an edge missing from a full table is dropped
  assign lane_we = (state_q == S_UPD) && (hit_q || (used_q < CntW'(MAX_EDGES)));

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [IdxW-1:0] idx;
    assign idx = row_base + IdxW'(l);
    esc_lane #(
      .KeyW    (KeyW),
      .Rows    (Rows),
      .RowBits (RowBits)
    ) u_lane (
      .clk_i    (clk_i),
      .we_i     (lane_we && (wr_lane_q == LaneBits'(l))),
      .wr_row_i (wr_row_q),
      .wr_key_i (key_q),
      .wr_cnt_i (new_cnt),
      .wr_dir_i (new_dir),
      .re_i     (state_q == S_READ),
      .rd_row_i (row_q),
      .en_i     (idx < used_x),
      .key_i    (key_q),
      .rd_o     (lane_rd[l])
    );
  end

  esc_merge #(
    .Lanes    (LANES),
    .LaneBits (LaneBits)
  ) u_merge (
    .lane_i (lane_rd),
    .rd_o   (mrg_rd),
    .lane_o (mrg_lane)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_KEY;
      S_KEY:  state_d = (used_q == '0) ? S_UPD : S_READ;
      S_READ: state_d = S_CMP;
      S_CMP:  state_d = (mrg_rd.hit || scan_end) ? S_UPD : S_READ;
      S_UPD: begin
        if (edge_q != EDGE_CA)  state_d = S_KEY;
        else if (last_q)        state_d = S_DONE;
        else                    state_d = S_IDLE;
      end
      S_DONE: if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      used_q        <= '0;
      n1_q          <= '0;
      n2_q          <= '0;
      orient_ok_q   <= 1'b1;
      manifold_ok_q <= 1'b1;
      overflow_q    <= 1'b0;
      require_fan_q <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) require_fan_q <= cfg_data_i[0];
      // in S_DONE the flag register is reloaded instead
      if (out_valid_q && m_axis_tready && (state_q != S_DONE)) out_valid_q <= 1'b0;
      case (state_q)
        S_UPD: begin
          if (!lane_we) begin
            overflow_q <= 1'b1;
          end else begin
            if (!hit_q) used_q <= used_q + CntW'(1);
            if (new_cnt > 2'd2) manifold_ok_q <= 1'b0;
            if (orient_fail) orient_ok_q <= 1'b0;
            // keep counts of entries on one face and on two faces
            case (old_cnt_q)
              2'd0: n1_q <= n1_q + CntW'(1);
              2'd1: begin
                n1_q <= n1_q - CntW'(1);
                n2_q <= n2_q + CntW'(1);
              end
              2'd2: n2_q <= n2_q - CntW'(1);
              default: ;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q   <= 1'b1;
            used_q        <= '0;
            n1_q          <= '0;
            n2_q          <= '0;
            orient_ok_q   <= 1'b1;
            manifold_ok_q <= 1'b1;
            overflow_q    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        va_q   <= s_axis_tdata[15:0];
        vb_q   <= s_axis_tdata[31:16];
        vc_q   <= s_axis_tdata[47:32];
        last_q <= s_axis_tlast;
        edge_q <= EDGE_AB;
      end
      S_KEY: begin
        from_q    <= v_from;
        to_q      <= v_to;
        key_q     <= {v_lo, v_hi};
        row_q     <= '0;
        hit_q     <= 1'b0;
        old_cnt_q <= 2'd0;
        old_dir_q <= DIR_NONE;
        wr_lane_q <= used_x[LaneBits-1:0];
        wr_row_q  <= used_x[LaneBits +: RowBits];
      end
      S_CMP: begin
        if (mrg_rd.hit) begin
          hit_q     <= 1'b1;
          old_cnt_q <= mrg_rd.cnt;
          old_dir_q <= mrg_rd.dir;
          wr_lane_q <= mrg_lane;
          wr_row_q  <= row_q;
        end else begin
          row_q <= row_q + RowBits'(1);
        end
      end
      S_UPD: edge_q <= edge_q + 2'd1;
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_flags_q[0] <= require_fan_q ? (n2_q == used_q) : (n1_q == '0);
          out_flags_q[1] <= orient_ok_q;
          out_flags_q[2] <= manifold_ok_q;
          out_flags_q[3] <= (n2_q == used_q) && orient_ok_q && manifold_ok_q;
          out_flags_q[4] <= overflow_q;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MAX_EDGES))
    else $error("edge fill count beyond table size");

  a_face_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IdxW'(n1_q) + IdxW'(n2_q)) <= used_x)
    else $error("face count tallies exceed entries in use");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new item taken while a triangle is in work");
`endif

endmodule

// ===== src/esc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_lane
// One bank of the edge table: key, count and direction, one row per read.
// ----------------------------------------------------------------------------
module esc_lane import esc_pkg::*; #(
  parameter int unsigned KeyW    = 2 * VertexBitsDef,
  parameter int unsigned Rows    = MaxEdgesDef / LanesDef,
  parameter int unsigned RowBits = 8
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [RowBits-1:0] wr_row_i,
  input  logic [KeyW-1:0]    wr_key_i,
  input  logic [1:0]         wr_cnt_i,
  input  logic [1:0]         wr_dir_i,
  input  logic               re_i,
  input  logic [RowBits-1:0] rd_row_i,
  input  logic               en_i,
  input  logic [KeyW-1:0]    key_i,
  output lane_rd_t           rd_o
);

  logic [KeyW-1:0] key_mem [Rows];
  logic [1:0]      cnt_mem [Rows];
  logic [1:0]      dir_mem [Rows];
  logic [KeyW-1:0] rd_key_q;
  logic [1:0]      rd_cnt_q;
  logic [1:0]      rd_dir_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[wr_row_i] <= wr_key_i;
      cnt_mem[wr_row_i] <= wr_cnt_i;
      dir_mem[wr_row_i] <= wr_dir_i;
    end
    if (re_i) begin
      rd_key_q <= key_mem[rd_row_i];
      rd_cnt_q <= cnt_mem[rd_row_i];
      rd_dir_q <= dir_mem[rd_row_i];
    end
  end

  assign rd_o.hit = en_i && (rd_key_q == key_i);
  assign rd_o.cnt = rd_cnt_q;
  assign rd_o.dir = rd_dir_q;

endmodule

// ===== src/esc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_merge
// Combines lane results: lowest hitting lane wins.
// ----------------------------------------------------------------------------
module esc_merge import esc_pkg::*; #(
  parameter int unsigned Lanes    = LanesDef,
  parameter int unsigned LaneBits = 2
) (
  input  lane_rd_t            lane_i [Lanes],
  output lane_rd_t            rd_o,
  output logic [LaneBits-1:0] lane_o
);

  always_comb begin
    rd_o   = '0;
    lane_o = '0;
    for (int i = Lanes - 1; i >= 0; i--) begin
      if (lane_i[i].hit) begin
        rd_o   = lane_i[i];
        lane_o = LaneBits'(i);
      end
    end
  end

endmodule
